>>> src/pbme_pkg.sv
`timescale 1ns / 1ps
// Package for the pixel blend mode engine: blend mode codes, fixed-point
// constants, lane pipeline types and the two constant lookup tables.
// No dependencies.
package pbme_pkg;

  // Default number of blended channels, and the number of channel fields.
  localparam int CHANNEL_COUNT_DEF = 3;
  localparam int MAX_LANES = 3;
  localparam int CH_W = 8;

  // Q1.16 channel format.
  localparam logic [16:0] FX_ONE = 17'h10000;
  localparam logic [16:0] FX_HALF = 17'h08000;

  // One quotient bit per divider stage.
  localparam int DIV_STEPS = 17;

  // Opacity in units of 1/256.
  localparam logic [8:0] OP_FULL = 9'd256;

  // Register indexes as decoded from paddr[2].
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_OPACITY = 1'b1;

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'd0,
    MODE_MULTIPLY = 4'd1,
    MODE_SCREEN = 4'd2,
    MODE_OVERLAY = 4'd3,
    MODE_SOFT = 4'd4,
    MODE_HARD = 4'd5,
    MODE_DIFF = 4'd6,
    MODE_EXCL = 4'd7,
    MODE_DARKEN = 4'd8,
    MODE_LIGHTEN = 4'd9,
    MODE_BURN = 4'd10,
    MODE_DODGE = 4'd11,
    MODE_LINBURN = 4'd12,
    MODE_LINDODGE = 4'd13,
    MODE_VIVID = 4'd14
  } mode_t;

  // One lane's word as it moves through the divider stages.
  typedef struct packed {
    logic [16:0] rem;
    logic [16:0] nlo;
    logic [16:0] quo;
    logic [16:0] dvs;
    logic        ovf;
    logic        burn;
    logic        dodge;
    logic [16:0] blnd;
    logic [16:0] a;
  } div_lane_t;

  typedef logic [16:0] fx_lut_t [256];

  // 8-bit intensity to Q1.16, x/255 rounded to nearest.
  function automatic fx_lut_t make_to_fx_lut();
    fx_lut_t lut;
    longint unsigned v;
    for (int i = 0; i < 256; i++) begin
      v = (longint'(i) * 65536 + 127) / 255;
      lut[i] = v[16:0];
    end
    return lut;
  endfunction

  // Q1.16 square root of each converted intensity.
  function automatic fx_lut_t make_sqrt_lut();
    fx_lut_t lut;
    longint unsigned x, v, res, bv;
    for (int i = 0; i < 256; i++) begin
      x = (longint'(i) * 65536 + 127) / 255;
      v = x << 16;
      res = 0;
      bv = 64'd1 << 32;
      while (bv > v) bv = bv >> 2;
      while (bv != 0) begin
        if (v >= res + bv) begin
          v = v - (res + bv);
          res = (res >> 1) + bv;
        end else begin
          res = res >> 1;
        end
        bv = bv >> 2;
      end
      lut[i] = res[16:0];
    end
    return lut;
  endfunction

  localparam fx_lut_t TO_FX_LUT = make_to_fx_lut();
  localparam fx_lut_t SQRT_LUT = make_sqrt_lut();

endpackage

>>> src/pixel_blend_mode_engine.sv
`timescale 1ns / 1ps
// Pixel blend mode engine: per-channel layer blend, opacity mix and
// rounding, in a pipeline with a 17-stage restoring divider.
// Depends on pbme_pkg.
//
// Usage:
//   The slave stream takes one word per pixel pair: base and top pixel,
//   three 8-bit channels each. The master stream gives one blended pixel
//   per accepted word, in order. The APB port holds the blend mode
//   (address 0) and opacity (address 4); write them only while no pixel is
//   in flight.
//   Throughput is one pixel per clock while the output is not stalled:
//   every stage is registered, and the burn and dodge quotients come
//   from a restoring divider that resolves one quotient bit per stage,
//   so its 17 stages make up most of the pipeline.
//   The whole pipeline advances together whenever the output register is
//   empty or being taken; while the receiver stalls a full output register,
//   s_tready is low and every stage holds its word.
//   Reset clears all valid bits, sets the blend mode to normal and opacity
//   to fully opaque.
module pixel_blend_mode_engine
  import pbme_pkg::*;
#(
  parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // base_blue, base_green, base_red, top_blue, top_green, top_red
  input  logic [47:0] s_tdata,
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_blue, out_green, out_red
  output logic [23:0] m_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LANES = (CHANNEL_COUNT > MAX_LANES) ? MAX_LANES : CHANNEL_COUNT;

  // Configuration registers.
  mode_t       mode_sel;
  logic [8:0]  opacity;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_sel <= MODE_NORMAL;
      opacity <= OP_FULL;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MODE) begin
        mode_sel <= mode_t'(pwdata[3:0]);
      end else begin
        opacity <= pwdata[8:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_OPACITY) ? {23'd0, opacity} : {28'd0, mode_sel};

  // Pipeline control: all stages move together.
  logic                 adv;
  logic                 v1, v2, vm, vo;
  logic [DIV_STEPS:0]   vd;

  assign adv = !vo || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vo;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      vd <= '0;
      vm <= 1'b0;
      vo <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
      v2 <= v1;
      vd <= {vd[DIV_STEPS-1:0], v2};
      vm <= vd[DIV_STEPS];
      vo <= vm;
    end
  end

  // Mode and saturated opacity travel with each word.
  mode_t       mode1, mode2;
  logic [8:0]  op1, op2;
  logic [8:0]  opd [0:DIV_STEPS];
  logic [8:0]  op_sat;

  assign op_sat = (opacity > OP_FULL) ? OP_FULL : opacity;

  always_ff @(posedge clk) begin
    if (adv) begin
      mode1 <= mode_sel;
      op1 <= op_sat;
      mode2 <= mode1;
      op2 <= op1;
      opd[0] <= op2;
      for (int j = 1; j <= DIV_STEPS; j++) begin
        opd[j] <= opd[j-1];
      end
    end
  end

  genvar lane, j;
  generate
    for (lane = 0; lane < MAX_LANES; lane++) begin : g_lane
      if (lane < LANES) begin : g_on
        logic [16:0] a1, b1, sq1;
        logic [33:0] pab2, pinv2;
        logic [16:0] sm2, a2, b2, n2, d2;
        logic        burn2, dodge2;
        div_lane_t   dv [0:DIV_STEPS];
        logic [24:0] rm;
        logic [7:0]  ob;

        // Stage 1: convert both channels to Q1.16 and look up the root.
        always_ff @(posedge clk) begin
          if (adv) begin
            a1 <= TO_FX_LUT[s_tdata[lane*CH_W +: CH_W]];
            b1 <= TO_FX_LUT[s_tdata[(lane+MAX_LANES)*CH_W +: CH_W]];
            sq1 <= SQRT_LUT[s_tdata[lane*CH_W +: CH_W]];
          end
        end

        // Stage 2: the three products and the divider operands.
        logic        blo1;
        logic [16:0] ia1, ib1, sx1, sy1, t1, n1, d1;
        logic [17:0] b1x2;
        logic [33:0] psm1;
        logic        burn1, dodge1;

        always_comb begin
          blo1 = b1 < FX_HALF;
          ia1 = FX_ONE - a1;
          ib1 = FX_ONE - b1;
          b1x2 = {b1, 1'b0};
          sx1 = blo1 ? 17'({1'b0, FX_ONE} - b1x2) : 17'(b1x2 - {1'b0, FX_ONE});
          sy1 = blo1 ? a1 : 17'(sq1 - a1);
          psm1 = sx1 * sy1;
          burn1 = (mode1 == MODE_BURN) || ((mode1 == MODE_VIVID) && blo1);
          dodge1 = (mode1 == MODE_DODGE) || ((mode1 == MODE_VIVID) && !blo1);
          if (burn1) begin
            t1 = (mode1 == MODE_BURN) ? b1 : b1x2[16:0];
            n1 = ia1;
            d1 = t1;
          end else begin
            t1 = (mode1 == MODE_DODGE) ? b1 : 17'(b1x2 - {1'b0, FX_ONE});
            n1 = a1;
            d1 = FX_ONE - t1;
          end
        end

        always_ff @(posedge clk) begin
          if (adv) begin
            pab2 <= a1 * b1;
            pinv2 <= ia1 * ib1;
            sm2 <= 17'((psm1 + 34'd32768) >> 16);
            a2 <= a1;
            b2 <= b1;
            n2 <= n1;
            d2 <= d1;
            burn2 <= burn1;
            dodge2 <= dodge1;
          end
        end

        // Stage 3: blend of the modes without a quotient, divider setup.
        logic [17:0] mab, m2ab, minv, m2inv;
        logic [33:0] psoft;
        logic [16:0] msoft, ia2, blnd2;
        logic signed [19:0] sa, sb, v, one;
        logic [32:0] nfull;
        div_lane_t   dinit;

        always_comb begin
          mab = 18'((pab2 + 34'd32768) >> 16);
          m2ab = 18'((({1'b0, pab2} << 1) + 35'd32768) >> 16);
          minv = 18'((pinv2 + 34'd32768) >> 16);
          m2inv = 18'((({1'b0, pinv2} << 1) + 35'd32768) >> 16);
          ia2 = FX_ONE - a2;
          psoft = sm2 * ia2;
          msoft = 17'((psoft + 34'd32768) >> 16);
          sa = $signed({3'd0, a2});
          sb = $signed({3'd0, b2});
          one = $signed({3'd0, FX_ONE});
          case (mode2)
            MODE_MULTIPLY: v = $signed({2'd0, mab});
            MODE_SCREEN:   v = one - $signed({2'd0, minv});
            MODE_OVERLAY:  v = (a2 < FX_HALF) ? $signed({2'd0, m2ab})
                                              : one - $signed({2'd0, m2inv});
            MODE_SOFT:     v = (b2 < FX_HALF) ? sa - $signed({3'd0, msoft})
                                              : sa + $signed({3'd0, sm2});
            MODE_HARD:     v = (b2 < FX_HALF) ? $signed({2'd0, m2ab})
                                              : one - $signed({2'd0, m2inv});
            MODE_DIFF:     v = (sa > sb) ? sa - sb : sb - sa;
            MODE_EXCL:     v = sa + sb - $signed({2'd0, m2ab});
            MODE_DARKEN:   v = (sa < sb) ? sa : sb;
            MODE_LIGHTEN:  v = (sa > sb) ? sa : sb;
            MODE_LINBURN:  v = sa + sb - one;
            MODE_LINDODGE: v = sa + sb;
            default:       v = sb;
          endcase
          if (v < 0) begin
            blnd2 = '0;
          end else if (v > one) begin
            blnd2 = FX_ONE;
          end else begin
            blnd2 = v[16:0];
          end

          // Rounded dividend n*2^16 + d/2; its upper part seeds the remainder.
          nfull = {n2, 16'd0} + {17'd0, d2[16:1]};
          dinit.ovf = {1'b0, nfull} >= {d2, 17'd0};
          dinit.rem = {1'b0, nfull[32:17]};
          dinit.nlo = nfull[16:0];
          dinit.quo = '0;
          dinit.dvs = d2;
          dinit.burn = burn2;
          dinit.dodge = dodge2;
          dinit.blnd = blnd2;
          dinit.a = a2;
        end

        always_ff @(posedge clk) begin
          if (adv) begin
            dv[0] <= dinit;
          end
        end

        // Divider: one restoring step per stage, most significant bit first.
        for (j = 1; j <= DIV_STEPS; j++) begin : g_div
          logic [17:0] rr;
          logic        ge;
          div_lane_t   nxt;

          always_comb begin
            rr = {dv[j-1].rem, dv[j-1].nlo[16]};
            ge = rr >= {1'b0, dv[j-1].dvs};
            nxt = dv[j-1];
            nxt.rem = ge ? 17'(rr - {1'b0, dv[j-1].dvs}) : rr[16:0];
            nxt.nlo = {dv[j-1].nlo[15:0], 1'b0};
            nxt.quo = {dv[j-1].quo[15:0], ge};
          end

          always_ff @(posedge clk) begin
            if (adv) begin
              dv[j] <= nxt;
            end
          end
        end

        // Mix stage: guards, quotient clamp, then blend against the base.
        logic [16:0] qc, dres, bl;
        logic        dzero;
        logic [24:0] rm_next;
        div_lane_t   dl;

        always_comb begin
          dl = dv[DIV_STEPS];
          dzero = dl.dvs == '0;
          qc = (dl.ovf || dl.quo > FX_ONE) ? FX_ONE : dl.quo;
          if (dl.burn) begin
            dres = dzero ? 17'd0 : 17'(FX_ONE - qc);
          end else begin
            dres = dzero ? FX_ONE : qc;
          end
          bl = (dl.burn || dl.dodge) ? dres : dl.blnd;
          rm_next = 25'(dl.a) * 25'(OP_FULL - opd[DIV_STEPS])
                    + 25'(bl) * 25'(opd[DIV_STEPS]);
        end

        always_ff @(posedge clk) begin
          if (adv) begin
            rm <= rm_next;
          end
        end

        // Output stage: scale to 8 bits with rounding and clamp.
        logic [32:0] sc;
        logic [7:0]  ob_next;

        always_comb begin
          sc = 33'(rm) * 33'd255 + 33'h0800000;
          ob_next = (sc[32:24] > 9'd255) ? 8'd255 : sc[31:24];
        end

        always_ff @(posedge clk) begin
          if (adv) begin
            ob <= ob_next;
          end
        end

        assign m_tdata[lane*CH_W +: CH_W] = ob;
      end else begin : g_off
        assign m_tdata[lane*CH_W +: CH_W] = '0;
      end
    end
  endgenerate

endmodule

>>> src/pbme_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the pixel blend mode engine, and its bind.
// Depends only on the ports of pixel_blend_mode_engine.
module pbme_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // A stalled output word stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its data.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("output word changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // An empty output register never blocks the input.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // A receiver that takes words never blocks the input.
  a_ready_taken: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output drains");

endmodule

bind pixel_blend_mode_engine pbme_checker u_pbme_checker (
  .clk(clk),
  .rst(rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata)
);
